// File: hw/rtl/imfe_pkg.sv
// Shared types, constants and the control sequence of the IMU motion feature extractor.
// No dependencies; every other file imports this package.
`default_nettype none
package imfe_pkg;

	// Bands per axis and derived widths
	localparam int BANDS_PER_AXIS = 8;
	localparam int BAND_CNT_W     = (2 * BANDS_PER_AXIS > 2) ? $clog2(2 * BANDS_PER_AXIS) : 1;
	localparam int BAND_W         = $clog2(BANDS_PER_AXIS + 1) + 19;

	// Fixed-point constants
	localparam logic [16:0] ONE_Q15   = 17'd32768;
	localparam logic [16:0] ONE_Q16   = 17'h10000;
	localparam logic [16:0] W_GYRO    = 17'd42598;
	localparam logic [16:0] W_ACCEL   = 17'd22938;
	localparam logic [16:0] MAG_MAX   = 17'h1FFFF;
	localparam logic [23:0] SPEED_MAX = 24'hFFFFFF;

	// Configuration register indexes
	localparam logic [2:0] REG_SPEED_ALPHA = 3'd0;
	localparam logic [2:0] REG_LEVEL_ALPHA = 3'd1;
	localparam logic [2:0] REG_GYRO_FS     = 3'd2;
	localparam logic [2:0] REG_LEVEL_FS    = 3'd3;
	localparam logic [2:0] REG_GRAVITY     = 3'd4;

	// Datapath operations, one per cycle while the controller runs; it pauses while a unit is busy
	typedef enum logic [5:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ_GX, OP_SQ_GY, OP_SQ_GZ,
		OP_SQ_AX, OP_SQ_AY, OP_SQ_AZ,
		OP_SQRT,
		OP_GLEN, OP_ALEN,
		OP_RX0, OP_RX1, OP_RAWX,
		OP_RY0, OP_RY1, OP_RAWY,
		OP_SMX0, OP_SMX1, OP_SXW,
		OP_SMY0, OP_SMY1, OP_SYW,
		OP_DIV_X, OP_SXN,
		OP_DIV_Y, OP_SYN,
		OP_DIV_L, OP_INST,
		OP_SML0, OP_SML1, OP_LVW,
		OP_SQ_SXN, OP_SQ_SYN,
		OP_SLEN
	} op_t;

	typedef struct packed {
		op_t  op;
		logic band_load;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
		logic band_last;
	} dp_status_t;

	localparam int          PROG_LEN  = 35;
	localparam logic [5:0]  PROG_LAST = 6'(PROG_LEN - 1);

	// Per-sample operation sequence
	function automatic op_t prog_op(input logic [5:0] pc);
		op_t op;
		case (pc)
			6'd0:  op = OP_SQ_GX;
			6'd1:  op = OP_SQ_GY;
			6'd2:  op = OP_SQ_GZ;
			6'd3:  op = OP_SQRT;
			6'd4:  op = OP_GLEN;
			6'd5:  op = OP_SQ_AX;
			6'd6:  op = OP_SQ_AY;
			6'd7:  op = OP_SQ_AZ;
			6'd8:  op = OP_SQRT;
			6'd9:  op = OP_ALEN;
			6'd10: op = OP_RX0;
			6'd11: op = OP_RX1;
			6'd12: op = OP_RAWX;
			6'd13: op = OP_RY0;
			6'd14: op = OP_RY1;
			6'd15: op = OP_RAWY;
			6'd16: op = OP_SMX0;
			6'd17: op = OP_SMX1;
			6'd18: op = OP_SXW;
			6'd19: op = OP_SMY0;
			6'd20: op = OP_SMY1;
			6'd21: op = OP_SYW;
			6'd22: op = OP_DIV_X;
			6'd23: op = OP_SXN;
			6'd24: op = OP_DIV_Y;
			6'd25: op = OP_SYN;
			6'd26: op = OP_DIV_L;
			6'd27: op = OP_INST;
			6'd28: op = OP_SML0;
			6'd29: op = OP_SML1;
			6'd30: op = OP_LVW;
			6'd31: op = OP_SQ_SXN;
			6'd32: op = OP_SQ_SYN;
			6'd33: op = OP_SQRT;
			6'd34: op = OP_SLEN;
			default: op = OP_NONE;
		endcase
		return op;
	endfunction

	// Operations that start a multi-cycle unit
	function automatic logic op_uses_unit(input op_t op);
		return (op == OP_SQRT) || (op == OP_DIV_X) || (op == OP_DIV_Y) || (op == OP_DIV_L);
	endfunction

	// Absolute value of a 16-bit two's complement word
	function automatic logic [16:0] abs16(input logic [15:0] v);
		return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/imu_motion_feature_extractor.sv
// IMU motion feature extractor, top level: controller plus datapath.
// From sample accept to the first band result the controller runs three roots and three
// divisions on shared units plus the multiply-accumulate steps; a division whose quotient
// saturates at once skips its iterations. A new sample is accepted only after all 16 band
// results of the last one are emitted; they follow one per cycle while the output is not stalled.
// Reset (arst_n low) clears the smoothing state and loads defaults.
// Depends on imfe_pkg, imfe_ctrl and imfe_dp.
`default_nettype none
module imu_motion_feature_extractor
	import imfe_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] gyro_x,
	input  wire logic signed [15:0] gyro_y,
	input  wire logic signed [15:0] gyro_z,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [16:0]             motion_magnitude,
	output logic [15:0]             speed_x_norm,
	output logic [15:0]             speed_y_norm,
	output logic [15:0]             level_smooth,
	output logic [15:0]             onset_value,
	output logic [3:0]              band_number,
	output logic [15:0]             band_level,
	output logic                    last_band
);

	dp_cmd_t    cmd;
	dp_status_t status;

	imfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	imfe_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.gyro_x           (gyro_x),
		.gyro_y           (gyro_y),
		.gyro_z           (gyro_z),
		.accel_x          (accel_x),
		.accel_y          (accel_y),
		.accel_z          (accel_z),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.motion_magnitude (motion_magnitude),
		.speed_x_norm     (speed_x_norm),
		.speed_y_norm     (speed_y_norm),
		.level_smooth     (level_smooth),
		.onset_value      (onset_value),
		.band_number      (band_number),
		.band_level       (band_level),
		.last_band        (last_band)
	);

endmodule
`default_nettype wire

// File: hw/rtl/imfe_sqrt.sv
// Iterative floor square root, 32-bit operand, one root bit per cycle.
// Depends on imfe_pkg.
`default_nettype none
module imfe_sqrt
	import imfe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] x,
	output logic             busy,
	output logic [15:0]      root
);

	logic [31:0] x_q;
	logic [17:0] rem_q;
	logic [15:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;

	logic [19:0] rem_w;
	logic [19:0] trial;
	logic        take;

	// Restoring step
	always_comb begin
		rem_w = {rem_q, x_q[31:30]};
		trial = {2'b00, root_q, 2'b01};
		take  = rem_w >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd16;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[29:0], 2'b00};
			rem_q  <= take ? 18'(rem_w - trial) : rem_w[17:0];
			root_q <= {root_q[14:0], take};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule
`default_nettype wire

// File: hw/rtl/imfe_div.sv
// Iterative normalizing divider: quotient clamped to 1.0 in Q1.15, one bit per cycle.
// Depends on imfe_pkg.
`default_nettype none
module imfe_div
	import imfe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] num,
	input  wire logic [15:0] den,
	output logic             busy,
	output logic [15:0]      quot
);

	logic [15:0] den_q;
	logic [15:0] rem_q;
	logic [16:0] num_q;
	logic [16:0] q_q;
	logic [4:0]  cnt_q;
	logic        busy_q;

	logic [15:0] den_eff;
	logic        ovf;
	logic [16:0] t;
	logic        take;

	// Zero divisor acts as one; a quotient of 2^17 or more saturates at once
	always_comb begin
		den_eff = (den == 16'd0) ? 16'd1 : den;
		ovf     = {1'b0, num[31:17]} >= den_eff;
		t       = {rem_q, num_q[16]};
		take    = t >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !ovf;
			cnt_q  <= 5'd17;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den_eff;
			rem_q <= {1'b0, num[31:17]};
			num_q <= num[16:0];
			q_q   <= ovf ? ONE_Q15 : 17'd0;
		end else if (busy_q) begin
			rem_q <= take ? 16'(t - {1'b0, den_q}) : t[15:0];
			num_q <= {num_q[15:0], 1'b0};
			q_q   <= {q_q[15:0], take};
		end
	end

	assign busy = busy_q;
	assign quot = (q_q > ONE_Q15) ? ONE_Q15[15:0] : q_q[15:0];

endmodule
`default_nettype wire

// File: hw/rtl/imfe_dp.sv
// Datapath: config registers, shared multiply-accumulate, state, band generator, output register.
// Depends on imfe_pkg, imfe_sqrt and imfe_div.
`default_nettype none
module imfe_dp
	import imfe_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	output dp_status_t              status,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic signed [15:0] gyro_x,
	input  wire logic signed [15:0] gyro_y,
	input  wire logic signed [15:0] gyro_z,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [16:0]             motion_magnitude,
	output logic [15:0]             speed_x_norm,
	output logic [15:0]             speed_y_norm,
	output logic [15:0]             level_smooth,
	output logic [15:0]             onset_value,
	output logic [3:0]              band_number,
	output logic [15:0]             band_level,
	output logic                    last_band
);

	// Configuration
	logic [15:0] speed_alpha_q;
	logic [15:0] level_alpha_q;
	logic [14:0] gyro_fs_q;
	logic [15:0] level_fs_q;
	logic [14:0] gravity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_alpha_q <= 16'd22938;
			level_alpha_q <= 16'd16384;
			gyro_fs_q     <= 15'd2048;
			level_fs_q    <= 16'd5120;
			gravity_q     <= 15'd2511;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED_ALPHA: speed_alpha_q <= cfg_data;
				REG_LEVEL_ALPHA: level_alpha_q <= cfg_data;
				REG_GYRO_FS:     gyro_fs_q     <= cfg_data[14:0];
				REG_LEVEL_FS:    level_fs_q    <= cfg_data;
				REG_GRAVITY:     gravity_q     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Sample and intermediate registers
	logic [16:0] gx_q, gy_q, gz_q, ax_q, ay_q, az_q;
	logic [15:0] glen_q;
	logic [16:0] mag_q;
	logic [23:0] rawx_q, rawy_q;
	logic [15:0] sxn_q, syn_q, inst_q, onset_q;
	logic [41:0] acc_q;

	// Persistent smoothing state
	logic [23:0] sx_q, sy_q;
	logic [16:0] lvl_q;
	logic [16:0] prev_q;

	// Shared units
	logic        sqrt_start, div_start;
	logic        sqrt_busy, div_busy;
	logic [15:0] root;
	logic [15:0] quot;
	logic [31:0] div_num;
	logic [15:0] div_den;

	assign sqrt_start = (cmd.op == OP_SQRT);
	assign div_start  = (cmd.op == OP_DIV_X) || (cmd.op == OP_DIV_Y) || (cmd.op == OP_DIV_L);

	always_comb begin
		case (cmd.op)
			OP_DIV_X: begin
				div_num = {1'b0, sx_q, 7'd0};
				div_den = {1'b0, gyro_fs_q};
			end
			OP_DIV_Y: begin
				div_num = {1'b0, sy_q, 7'd0};
				div_den = {1'b0, gyro_fs_q};
			end
			default: begin
				div_num = {mag_q, 15'd0};
				div_den = level_fs_q;
			end
		endcase
	end

	imfe_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (acc_q[31:0]),
		.busy   (sqrt_busy),
		.root   (root)
	);

	imfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (quot)
	);

	// Multiply-accumulate operand selection
	logic [23:0] mac_a;
	logic [16:0] mac_b;
	logic [41:0] mac_init;
	logic        mac_en, mac_clr;
	logic [40:0] prod;

	always_comb begin
		mac_a    = '0;
		mac_b    = '0;
		mac_init = '0;
		mac_en   = 1'b1;
		mac_clr  = 1'b0;
		case (cmd.op)
			OP_SQ_GX:  begin mac_a = 24'(gx_q); mac_b = gx_q; mac_clr = 1'b1; end
			OP_SQ_GY:  begin mac_a = 24'(gy_q); mac_b = gy_q; end
			OP_SQ_GZ:  begin mac_a = 24'(gz_q); mac_b = gz_q; end
			OP_SQ_AX:  begin mac_a = 24'(ax_q); mac_b = ax_q; mac_clr = 1'b1; end
			OP_SQ_AY:  begin mac_a = 24'(ay_q); mac_b = ay_q; end
			OP_SQ_AZ:  begin mac_a = 24'(az_q); mac_b = az_q; end
			OP_RX0: begin
				mac_a = 24'(gz_q); mac_b = W_GYRO; mac_clr = 1'b1; mac_init = 42'd128;
			end
			OP_RX1:    begin mac_a = 24'(ax_q); mac_b = W_ACCEL; end
			OP_RY0: begin
				mac_a = 24'(gx_q); mac_b = W_GYRO; mac_clr = 1'b1; mac_init = 42'd128;
			end
			OP_RY1:    begin mac_a = 24'(ay_q); mac_b = W_ACCEL; end
			OP_SMX0: begin
				mac_a = sx_q; mac_b = ONE_Q16 - {1'b0, speed_alpha_q};
				mac_clr = 1'b1; mac_init = 42'd32768;
			end
			OP_SMX1:   begin mac_a = rawx_q; mac_b = {1'b0, speed_alpha_q}; end
			OP_SMY0: begin
				mac_a = sy_q; mac_b = ONE_Q16 - {1'b0, speed_alpha_q};
				mac_clr = 1'b1; mac_init = 42'd32768;
			end
			OP_SMY1:   begin mac_a = rawy_q; mac_b = {1'b0, speed_alpha_q}; end
			OP_SML0: begin
				mac_a = 24'(lvl_q); mac_b = ONE_Q16 - {1'b0, level_alpha_q};
				mac_clr = 1'b1; mac_init = 42'd32768;
			end
			OP_SML1:   begin mac_a = 24'(inst_q); mac_b = {1'b0, level_alpha_q}; end
			OP_SQ_SXN: begin mac_a = 24'(sxn_q); mac_b = 17'(sxn_q); mac_clr = 1'b1; end
			OP_SQ_SYN: begin mac_a = 24'(syn_q); mac_b = 17'(syn_q); end
			default:   mac_en = 1'b0;
		endcase
		prod = 41'(mac_a) * 41'(mac_b);
	end

	// Magnitude, raw-speed saturation and onset
	logic [16:0] dev;
	logic [17:0] msum;
	logic [23:0] raw_sat;
	logic [16:0] slen_w;
	logic [16:0] rise;

	always_comb begin
		dev     = ({1'b0, root} >= {2'b00, gravity_q}) ? 17'({1'b0, root} - {2'b00, gravity_q})
		                                               : 17'({2'b00, gravity_q} - {1'b0, root});
		msum    = {2'b00, glen_q} + {1'b0, dev};
		raw_sat = (acc_q[41:32] != 10'd0) ? SPEED_MAX : acc_q[31:8];
		slen_w  = {1'b0, root};
		rise    = (slen_w > prev_q) ? (slen_w - prev_q) : 17'd0;
	end

	// Operation results
	always_ff @(posedge clk) begin
		if (mac_en) begin
			acc_q <= (mac_clr ? mac_init : acc_q) + 42'(prod);
		end
		case (cmd.op)
			OP_LOAD: begin
				gx_q <= abs16(gyro_x);
				gy_q <= abs16(gyro_y);
				gz_q <= abs16(gyro_z);
				ax_q <= abs16(accel_x);
				ay_q <= abs16(accel_y);
				az_q <= abs16(accel_z);
			end
			OP_GLEN: glen_q <= root;
			OP_ALEN: mag_q  <= msum[17] ? MAG_MAX : msum[16:0];
			OP_RAWX: rawx_q <= raw_sat;
			OP_RAWY: rawy_q <= raw_sat;
			OP_SXN:  sxn_q  <= quot;
			OP_SYN:  syn_q  <= quot;
			OP_INST: inst_q <= quot;
			OP_SLEN: onset_q <= (rise > ONE_Q15) ? ONE_Q15[15:0] : rise[15:0];
			default: ;
		endcase
	end

	// Smoothing state and previous length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q   <= '0;
			sy_q   <= '0;
			lvl_q  <= '0;
			prev_q <= '0;
		end else begin
			case (cmd.op)
				OP_SXW:  sx_q   <= acc_q[39:16];
				OP_SYW:  sy_q   <= acc_q[39:16];
				OP_LVW:  lvl_q  <= acc_q[32:16];
				OP_SLEN: prev_q <= slen_w;
				default: ;
			endcase
		end
	end

	// Band counters
	logic [BAND_CNT_W-1:0] k_q;
	logic [BAND_CNT_W-1:0] idx_q;
	logic                  axis_q;
	logic                  band_last;
	logic                  idx_wrap;

	assign band_last = (k_q == BAND_CNT_W'(2 * BANDS_PER_AXIS - 1));
	assign idx_wrap  = (idx_q == BAND_CNT_W'(BANDS_PER_AXIS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			idx_q  <= '0;
			axis_q <= 1'b0;
		end else if (cmd.band_load) begin
			if (band_last) begin
				k_q    <= '0;
				idx_q  <= '0;
				axis_q <= 1'b0;
			end else begin
				k_q <= k_q + 1'b1;
				if (idx_wrap) begin
					idx_q  <= '0;
					axis_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// Triangular band activation
	logic [15:0]           band_v;
	logic [BAND_W-1:0]     vb, center, band_dist;
	logic [15:0]           act;
	logic [BAND_CNT_W+3:0] k_ext;

	always_comb begin
		band_v    = axis_q ? syn_q : sxn_q;
		vb        = BAND_W'(band_v) * BAND_W'(BANDS_PER_AXIS);
		center    = BAND_W'({idx_q, 1'b1, 14'd0});
		band_dist = (vb >= center) ? (vb - center) : (center - vb);
		act       = (band_dist < BAND_W'(ONE_Q15)) ? 16'(ONE_Q15 - 17'(band_dist[14:0])) : 16'd0;
		k_ext     = {4'd0, k_q};
	end

	// Output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.band_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.band_load) begin
			motion_magnitude <= mag_q;
			speed_x_norm     <= sxn_q;
			speed_y_norm     <= syn_q;
			level_smooth     <= lvl_q[15:0];
			onset_value      <= onset_q;
			band_number      <= k_ext[3:0];
			band_level       <= act;
			last_band        <= band_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign status.busy      = sqrt_busy || div_busy;
	assign status.out_free  = !out_valid_q || out_ready;
	assign status.band_last = band_last;

endmodule
`default_nettype wire

// File: hw/rtl/imfe_ctrl.sv
// Controller: steps through the per-sample operation sequence, waits on units, emits bands.
// Depends on imfe_pkg.
`default_nettype none
module imfe_ctrl
	import imfe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic [5:0] pc_q;
	op_t        cur_op;

	assign cur_op = prog_op(pc_q);

	// Command decode
	always_comb begin
		cmd.op        = OP_NONE;
		cmd.band_load = 1'b0;
		case (state_q)
			ST_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
			ST_RUN:  cmd.op = cur_op;
			ST_EMIT: cmd.band_load = status.out_free;
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	// State and sequence counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						pc_q    <= '0;
					end
				end
				ST_RUN: begin
					if (op_uses_unit(cur_op)) begin
						state_q <= ST_WAIT;
					end else if (pc_q == PROG_LAST) begin
						state_q <= ST_EMIT;
					end else begin
						pc_q <= pc_q + 6'd1;
					end
				end
				ST_WAIT: begin
					if (!status.busy) begin
						state_q <= ST_RUN;
						pc_q    <= pc_q + 6'd1;
					end
				end
				ST_EMIT: begin
					if (status.out_free && status.band_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
